>>> rtl/trn_pkg.sv
package trn_pkg;

  // Telnet command codes
  localparam logic [7:0] CMD_IAC  = 8'd255;
  localparam logic [7:0] CMD_SE   = 8'd240;
  localparam logic [7:0] CMD_SB   = 8'd250;
  localparam logic [7:0] CMD_WILL = 8'd251;
  localparam logic [7:0] CMD_WONT = 8'd252;
  localparam logic [7:0] CMD_DO   = 8'd253;
  localparam logic [7:0] CMD_DONT = 8'd254;

  // Options and subnegotiation codes
  localparam logic [7:0] OPT_ECHO  = 8'd1;
  localparam logic [7:0] OPT_SGA   = 8'd3;
  localparam logic [7:0] OPT_TTYPE = 8'd24;
  localparam logic [7:0] TT_SEND   = 8'd1;
  localparam logic [7:0] TT_IS     = 8'd0;

  localparam logic [7:0] CHR_NUL       = 8'd0;
  localparam logic [7:0] CHR_ESC       = 8'd27;
  localparam logic [7:0] ESC_END_ABOVE = 8'd64;

  localparam int unsigned IDX_W = 4;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_REPLY,
    KIND_NAME_NVT,
    KIND_NAME_ANSI
  } trn_kind_t;

  // One queued request: a display byte, a 3-byte reply, or a terminal-type answer
  typedef struct packed {
    trn_kind_t  kind;
    logic [7:0] val;
    logic [7:0] cmd;
  } trn_req_t;

  function automatic logic [IDX_W-1:0] trn_last_index(trn_kind_t kind);
    logic [IDX_W-1:0] r;
    unique case (kind)
      KIND_DATA:      r = IDX_W'(0);
      KIND_REPLY:     r = IDX_W'(2);
      KIND_NAME_NVT:  r = IDX_W'(8);
      KIND_NAME_ANSI: r = IDX_W'(9);
      default:        r = IDX_W'(0);
    endcase
    return r;
  endfunction

  function automatic logic [7:0] trn_byte(trn_req_t r, logic [IDX_W-1:0] idx);
    logic [7:0] b;
    b = CMD_IAC;
    unique case (r.kind)
      KIND_DATA: b = r.val;
      KIND_REPLY: begin
        case (idx)
          IDX_W'(0): b = CMD_IAC;
          IDX_W'(1): b = r.cmd;
          default:   b = r.val;
        endcase
      end
      KIND_NAME_NVT: begin
        case (idx)
          IDX_W'(0): b = CMD_IAC;
          IDX_W'(1): b = CMD_SB;
          IDX_W'(2): b = OPT_TTYPE;
          IDX_W'(3): b = TT_IS;
          IDX_W'(4): b = 8'h4E;
          IDX_W'(5): b = 8'h56;
          IDX_W'(6): b = 8'h54;
          IDX_W'(7): b = CMD_IAC;
          default:   b = CMD_SE;
        endcase
      end
      default: begin
        case (idx)
          IDX_W'(0): b = CMD_IAC;
          IDX_W'(1): b = CMD_SB;
          IDX_W'(2): b = OPT_TTYPE;
          IDX_W'(3): b = TT_IS;
          IDX_W'(4): b = 8'h41;
          IDX_W'(5): b = 8'h4E;
          IDX_W'(6): b = 8'h53;
          IDX_W'(7): b = 8'h49;
          IDX_W'(8): b = CMD_IAC;
          default:   b = CMD_SE;
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

>>> rtl/trn_in_if.sv
interface trn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

>>> rtl/trn_out_if.sv
interface trn_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_dest;
  logic       last;

  modport source (output valid, output out_byte, output out_dest, output last, input ready);
  modport sink (input valid, input out_byte, input out_dest, input last, output ready);
endinterface

>>> rtl/trn_decode.sv
module trn_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        in_byte,
  output trn_pkg::trn_req_t req,
  output logic              req_valid
);
  import trn_pkg::*;

  typedef enum logic [1:0] {PH_DATA, PH_CODE, PH_OPTION} phase_t;
  typedef enum logic [2:0] {V_SB, V_WILL, V_WONT, V_DO, V_DONT} verb_t;
  typedef enum logic [1:0] {H_NVT, H_ANSI, H_TTYPE, H_DISCARD} handler_t;
  typedef enum logic [1:0] {E_NORMAL, E_ESC, E_SEQ} esc_t;

  phase_t   phase, phase_next;
  verb_t    verb, verb_next;
  handler_t handler, handler_next;
  esc_t     esc, esc_next;
  logic [1:0] pick, pick_next;
  logic     run;

  always_comb begin
    phase_next   = phase;
    verb_next    = verb;
    handler_next = handler;
    esc_next     = esc;
    pick_next    = pick;
    run          = 1'b0;
    req_valid    = 1'b0;
    req          = '{kind: KIND_DATA, val: in_byte, cmd: CMD_IAC};

    unique case (phase)
      PH_CODE: begin
        phase_next = PH_DATA;
        case (in_byte)
          CMD_IAC:  run = 1'b1;
          CMD_SE:   handler_next = (pick == 2'd0) ? H_NVT : H_ANSI;
          CMD_SB:   begin verb_next = V_SB;   phase_next = PH_OPTION; end
          CMD_WILL: begin verb_next = V_WILL; phase_next = PH_OPTION; end
          CMD_WONT: begin verb_next = V_WONT; phase_next = PH_OPTION; end
          CMD_DO:   begin verb_next = V_DO;   phase_next = PH_OPTION; end
          CMD_DONT: begin verb_next = V_DONT; phase_next = PH_OPTION; end
          default:  ;
        endcase
      end
      PH_OPTION: begin
        phase_next = PH_DATA;
        req.kind   = KIND_REPLY;
        if (verb == V_SB) begin
          handler_next = (in_byte == OPT_TTYPE) ? H_TTYPE : H_DISCARD;
        end else if (in_byte == OPT_SGA) begin
          req_valid = 1'b0;
        end else if (in_byte == OPT_ECHO) begin
          req_valid = (verb == V_WILL) || (verb == V_WONT) || (verb == V_DO) ||
                      (verb == V_DONT);
          if (verb == V_WILL)      req.cmd = CMD_DO;
          else if (verb == V_WONT) req.cmd = CMD_DONT;
          else                     req.cmd = CMD_WONT;
        end else if (in_byte == OPT_TTYPE) begin
          req_valid = (verb == V_WILL) || (verb == V_DO);
          req.cmd   = (verb == V_WILL) ? CMD_DONT : CMD_WILL;
        end else begin
          req_valid = (verb == V_WILL) || (verb == V_DO);
          req.cmd   = (verb == V_WILL) ? CMD_DONT : CMD_WONT;
        end
      end
      default: begin
        phase_next = PH_DATA;
        if (in_byte == CMD_IAC) phase_next = PH_CODE;
        else                    run = 1'b1;
      end
    endcase

    if (run) begin
      unique case (handler)
        H_NVT: req_valid = (in_byte != CHR_NUL);
        H_ANSI: begin
          unique case (esc)
            E_ESC: esc_next = E_SEQ;
            E_SEQ: if (in_byte > ESC_END_ABOVE) esc_next = E_NORMAL;
            default: begin
              esc_next = E_NORMAL;
              if (in_byte == CHR_ESC)      esc_next = E_ESC;
              else if (in_byte != CHR_NUL) req_valid = 1'b1;
            end
          endcase
        end
        H_TTYPE: begin
          if (in_byte == TT_SEND) begin
            pick_next = (pick >= 2'd2) ? 2'd0 : pick + 2'd1;
            req_valid = 1'b1;
            req.kind  = (pick_next == 2'd0) ? KIND_NAME_NVT : KIND_NAME_ANSI;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_DATA;
      verb    <= V_SB;
      handler <= H_NVT;
      esc     <= E_NORMAL;
      pick    <= 2'd0;
    end else if (fire) begin
      phase   <= phase_next;
      verb    <= verb_next;
      handler <= handler_next;
      esc     <= esc_next;
      pick    <= pick_next;
    end
  end

endmodule

>>> rtl/trn_emit.sv
module trn_emit (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  trn_pkg::trn_req_t req,
  output logic              free,
  trn_out_if.source         tx
);
  import trn_pkg::*;

  logic             valid;
  trn_req_t         cur;
  logic [IDX_W-1:0] idx;
  logic             last_i;

  assign last_i = (idx == trn_last_index(cur.kind));
  // Open for a new request when empty or when the final byte leaves now
  assign free   = !valid || (tx.ready && last_i);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
      cur   <= req;
      idx   <= '0;
    end else if (valid && tx.ready) begin
      if (last_i) valid <= 1'b0;
      else        idx   <= idx + IDX_W'(1);
    end
  end

  assign tx.valid    = valid;
  assign tx.out_byte = trn_byte(cur, idx);
  assign tx.out_dest = (cur.kind != KIND_DATA);
  assign tx.last     = last_i;

endmodule

>>> rtl/telnet_receive_negotiator_top.sv
// Channel | Dir | Payload                    | Role
// rx      | in  | in_byte[7:0]               | received telnet bytes
// tx      | out | out_byte[7:0], out_dest, last | display bytes (dest 0), replies (dest 1)
//
// One received byte is decoded in the cycle it is accepted; the result leaves
// from an output register the next cycle, one byte per cycle while tx is ready.
// Display bytes and zero-result bytes sustain one request per cycle while tx is ready.
// A 3-byte reply or a terminal-type answer holds rx until its last byte is taken;
// the output sequencer is the only thing that throttles input.
// rst is synchronous: decoder returns to data phase with the NVT handler.
module telnet_receive_negotiator_top (
  input  logic      clk,
  input  logic      rst,
  trn_in_if.sink    rx,
  trn_out_if.source tx
);
  import trn_pkg::*;

  trn_req_t req;
  logic     req_valid;
  logic     free;
  logic     fire;

  // Take a new request whenever the sequencer is empty or finishing
  assign rx.ready = free;
  assign fire     = rx.valid && rx.ready;

  // Protocol state and request decode; state advances only on an accepted byte
  trn_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .in_byte   (rx.in_byte),
    .req       (req),
    .req_valid (req_valid)
  );

  // Output sequencer: expand the request into its byte stream, mark the last
  trn_emit u_emit (
    .clk  (clk),
    .rst  (rst),
    .load (fire && req_valid),
    .req  (req),
    .free (free),
    .tx   (tx)
  );

endmodule

>>> rtl/trn_check.sv
module trn_check (
  input logic       clk,
  input logic       rst,
  input logic       rx_ready,
  input logic       tx_valid,
  input logic       tx_ready,
  input logic [7:0] tx_out_byte,
  input logic       tx_out_dest,
  input logic       tx_last
);

  // Display data is always a single-byte request
  a_data_single: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_out_dest |-> tx_last)
    else $error("display byte without last");

  // Input stalls only while a result is still going out
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !rx_ready |-> tx_valid && !(tx_ready && tx_last))
    else $error("input stalled with nothing pending");

  // A taken non-final byte is followed by a further byte for the peer
  a_continue: assert property (@(posedge clk) disable iff (rst)
    tx_valid && tx_ready && !tx_last |=> tx_valid && tx_out_dest)
    else $error("reply stream broke off");

  // Hold the offered byte while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_ready |=> tx_valid && $stable(tx_out_byte))
    else $error("output changed under stall");

endmodule

bind telnet_receive_negotiator_top trn_check u_check (
  .clk         (clk),
  .rst         (rst),
  .rx_ready    (rx.ready),
  .tx_valid    (tx.valid),
  .tx_ready    (tx.ready),
  .tx_out_byte (tx.out_byte),
  .tx_out_dest (tx.out_dest),
  .tx_last     (tx.last)
);

>>> tb/tb.sv
module tb;
  import trn_pkg::*;

  // Run limits: the watchdog covers the long receiver hold-off with plenty to spare.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 20;
  localparam int MAX_BURST      = 10;

  localparam logic DEST_HOST = 1'b0;
  localparam logic DEST_PEER = 1'b1;

  // A command byte with no meaning to the block, and an option it does not know.
  localparam logic [7:0] CMD_NOP   = 8'd241;
  localparam logic [7:0] OPT_OTHER = 8'h80;

  typedef enum logic [1:0] {PH_DATA, PH_CMD, PH_OPT} rx_phase_t;
  typedef enum logic [2:0] {NEG_SB, NEG_WILL, NEG_WONT, NEG_DO, NEG_DONT} neg_verb_t;
  typedef enum logic [1:0] {HND_NVT, HND_ANSI, HND_TTYPE, HND_DISCARD} handler_sel_t;
  typedef enum logic [1:0] {ESC_NORMAL, ESC_SEEN, ESC_SEQ} esc_state_t;

  typedef struct {
    logic [7:0] val;
    logic       dest;
    logic       last;
  } owed_byte_t;

  logic clk;
  logic rst;

  trn_in_if  rx ();
  trn_out_if tx ();

  telnet_receive_negotiator_top dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx),
    .tx  (tx)
  );

  // Decoder state as the block should hold it.
  rx_phase_t    m_phase;
  neg_verb_t    m_verb;
  handler_sel_t m_handler;
  esc_state_t   m_esc;
  logic [1:0]   m_pick;

  // Bytes the block owes us, oldest first; step_bytes collects one request's output.
  owed_byte_t owed_bytes[$];
  owed_byte_t step_bytes[$];

  int requests_sent;
  int mismatches;
  int quiet_cycles;

  // Idle knobs, changed between test phases.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // Bump hold_armed to make the receiver hold off for HOLD_CYCLES.
  int hold_armed;
  int hold_taken;
  int hold_left;

  // ---------------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------------

  function void push_out(logic [7:0] b, logic dest);
    // Cap at the block's largest burst, the ten-byte ANSI answer.
    if (step_bytes.size() < MAX_BURST) step_bytes.push_back('{val: b, dest: dest, last: 1'b0});
  endfunction

  function void push_reply(logic [7:0] cmd, logic [7:0] opt);
    push_out(CMD_IAC, DEST_PEER);
    push_out(cmd, DEST_PEER);
    push_out(opt, DEST_PEER);
  endfunction

  // Route one payload byte through whichever handler is active.
  function void feed_handler(logic [7:0] b);
    string name;
    case (m_handler)
      HND_NVT: begin
        if (b != CHR_NUL) push_out(b, DEST_HOST);
      end
      HND_ANSI: begin
        case (m_esc)
          ESC_SEEN: m_esc = ESC_SEQ;
          ESC_SEQ: begin
            // Anything above '@' closes the escape sequence.
            if (b > ESC_END_ABOVE) m_esc = ESC_NORMAL;
          end
          default: begin
            m_esc = ESC_NORMAL;
            if (b == CHR_ESC) m_esc = ESC_SEEN;
            else if (b != CHR_NUL) push_out(b, DEST_HOST);
          end
        endcase
      end
      HND_TTYPE: begin
        if (b == TT_SEND) begin
          // Advance the terminal name first, then answer with it.
          m_pick = (m_pick >= 2'd2) ? 2'd0 : m_pick + 2'd1;
          name = (m_pick == 2'd0) ? "NVT" : "ANSI";
          push_out(CMD_IAC, DEST_PEER);
          push_out(CMD_SB, DEST_PEER);
          push_out(OPT_TTYPE, DEST_PEER);
          push_out(TT_IS, DEST_PEER);
          for (int i = 0; i < name.len(); i++) push_out(name[i], DEST_PEER);
          push_out(CMD_IAC, DEST_PEER);
          push_out(CMD_SE, DEST_PEER);
        end
      end
      default: ;
    endcase
  endfunction

  // Advance the decoder by one received byte and queue what it must emit.
  function void decode_rx_byte(logic [7:0] b);
    step_bytes.delete();
    case (m_phase)
      PH_CMD: begin
        m_phase = PH_DATA;
        case (b)
          CMD_IAC:  feed_handler(b);
          CMD_SE:   m_handler = (m_pick == 2'd0) ? HND_NVT : HND_ANSI;
          CMD_SB:   begin m_verb = NEG_SB;   m_phase = PH_OPT; end
          CMD_WILL: begin m_verb = NEG_WILL; m_phase = PH_OPT; end
          CMD_WONT: begin m_verb = NEG_WONT; m_phase = PH_OPT; end
          CMD_DO:   begin m_verb = NEG_DO;   m_phase = PH_OPT; end
          CMD_DONT: begin m_verb = NEG_DONT; m_phase = PH_OPT; end
          default: ;
        endcase
      end
      PH_OPT: begin
        m_phase = PH_DATA;
        if (m_verb == NEG_SB) begin
          m_handler = (b == OPT_TTYPE) ? HND_TTYPE : HND_DISCARD;
        end else if (b == OPT_ECHO) begin
          case (m_verb)
            NEG_WILL: push_reply(CMD_DO, b);
            NEG_WONT: push_reply(CMD_DONT, b);
            default:  push_reply(CMD_WONT, b);
          endcase
        end else if (b == OPT_TTYPE) begin
          if (m_verb == NEG_WILL) push_reply(CMD_DONT, b);
          else if (m_verb == NEG_DO) push_reply(CMD_WILL, b);
        end else if (b != OPT_SGA) begin
          if (m_verb == NEG_WILL) push_reply(CMD_DONT, b);
          else if (m_verb == NEG_DO) push_reply(CMD_WONT, b);
        end
      end
      default: begin
        if (b == CMD_IAC) m_phase = PH_CMD;
        else feed_handler(b);
      end
    endcase
    if (step_bytes.size() != 0) step_bytes[step_bytes.size() - 1].last = 1'b1;
    foreach (step_bytes[i]) owed_bytes.push_back(step_bytes[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, receiver, checker, watchdog
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: stall at random, or hold off for a long stretch on request.
  initial begin
    tx.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed != hold_taken) begin
        hold_taken = hold_armed;
        hold_left = HOLD_CYCLES;
        tx.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left = hold_left - 1;
        tx.ready <= 1'b0;
      end else begin
        tx.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Compare every accepted output byte against the oldest owed byte.
  always @(posedge clk) begin
    owed_byte_t want;
    if (!rst && tx.valid && tx.ready) begin
      if (owed_bytes.size() == 0) begin
        $display("%0t: unexpected byte %02h dest %0b last %0b",
                 $time, tx.out_byte, tx.out_dest, tx.last);
        mismatches++;
      end else begin
        want = owed_bytes.pop_front();
        if (tx.out_byte !== want.val || tx.out_dest !== want.dest || tx.last !== want.last) begin
          $display("%0t: expected byte %02h dest %0b last %0b, got byte %02h dest %0b last %0b",
                   $time, want.val, want.dest, want.last,
                   tx.out_byte, tx.out_dest, tx.last);
          mismatches++;
        end
      end
    end
  end

  // End the run if neither side moves for too long.
  always @(posedge clk) begin
    if (rst || (rx.valid && rx.ready) || (tx.valid && tx.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d bytes still owed",
               $time, WATCHDOG_LIMIT, owed_bytes.size());
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offer one request, idling first at random; keep valid high across back-to-back requests.
  task automatic send_byte(logic [7:0] b);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      rx.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    rx.valid   <= 1'b1;
    rx.in_byte <= b;
    do @(posedge clk); while (!rx.ready);
    decode_rx_byte(b);
    requests_sent++;
  endtask

  task automatic send_negotiation(logic [7:0] cmd, logic [7:0] opt);
    send_byte(CMD_IAC);
    send_byte(cmd);
    send_byte(opt);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Plain data in the NVT handler: NUL dropped, doubled IAC as data, stray command ignored.
  task automatic test_display_bytes();
    send_byte(CHR_NUL);
    send_byte(8'h41);
    send_byte(8'hFE);
    send_byte(CMD_IAC);
    send_byte(CMD_IAC);
    send_byte(CMD_IAC);
    send_byte(CMD_NOP);
  endtask

  // One of each reply family plus the SGA no-reply case; silent options and the rest come later.
  task automatic test_option_replies();
    send_negotiation(CMD_WILL, OPT_ECHO);
    send_negotiation(CMD_DO, OPT_TTYPE);
    send_negotiation(CMD_DO, OPT_OTHER);
    send_negotiation(CMD_WILL, OPT_SGA);
  endtask

  // Ask for the terminal type, close the subnegotiation so ANSI takes over, then strip
  // an escape sequence while plain text and NUL go through the ANSI rules.
  task automatic test_terminal_type();
    send_byte(CMD_IAC);
    send_byte(CMD_SB);
    send_byte(OPT_TTYPE);
    send_byte(TT_SEND);
    send_byte(CMD_IAC);
    send_byte(CMD_SE);
    send_byte(CHR_ESC);
    send_byte("[");
    send_byte("m");
    send_byte("x");
    send_byte(CHR_NUL);
  endtask

  // Hold the receiver off while replies pile up, so the block must stall rx.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_armed++;
    repeat (10) send_negotiation(CMD_DO, OPT_ECHO);
  endtask

  // Mostly well-formed telnet traffic with random content, plus some raw noise.
  task automatic test_random_traffic(int goal, int unsigned idle_pct, int unsigned stall_pct);
    int stop_at;
    int unsigned pick;
    int unsigned body_len;
    logic [7:0] verb;
    logic [7:0] opt;
    logic [7:0] b;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = requests_sent + goal;
    while (requests_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        // Raw byte: may be an IAC that starts a command on its own.
        send_byte(8'($urandom_range(255)));
      end else if (pick < 58) begin
        case ($urandom_range(3))
          0:       verb = CMD_WILL;
          1:       verb = CMD_WONT;
          2:       verb = CMD_DO;
          default: verb = CMD_DONT;
        endcase
        case ($urandom_range(3))
          0:       opt = OPT_ECHO;
          1:       opt = OPT_SGA;
          2:       opt = OPT_TTYPE;
          default: opt = 8'($urandom_range(255));
        endcase
        send_negotiation(verb, opt);
      end else if (pick < 75) begin
        // Subnegotiation: mostly terminal type, else an option that gets discarded.
        opt = ($urandom_range(3) != 0) ? OPT_TTYPE : 8'($urandom_range(255));
        send_byte(CMD_IAC);
        send_byte(CMD_SB);
        send_byte(opt);
        body_len = $urandom_range(1, 4);
        repeat (body_len) begin
          b = ($urandom_range(9) < 6) ? TT_SEND : 8'($urandom_range(255));
          send_byte(b);
          if (b == CMD_IAC) send_byte(CMD_IAC);
        end
        send_byte(CMD_IAC);
        send_byte(CMD_SE);
      end else if (pick < 92) begin
        // Escape sequence: ESC, introducer, parameter digits, final byte.
        send_byte(CHR_ESC);
        send_byte(($urandom_range(3) != 0) ? 8'h5B : 8'($urandom_range(255)));
        repeat ($urandom_range(3)) send_byte(8'($urandom_range(48, 57)));
        send_byte(8'($urandom_range(65, 126)));
      end else begin
        send_byte(CMD_IAC);
        send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst = 1'b1;
    rx.valid = 1'b0;
    rx.in_byte = 8'h00;
    requests_sent = 0;
    mismatches = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_armed = 0;
    hold_taken = 0;
    hold_left = 0;
    m_phase = PH_DATA;
    m_verb = NEG_SB;
    m_handler = HND_NVT;
    m_esc = ESC_NORMAL;
    m_pick = 2'd0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_display_bytes();
    test_option_replies();
    test_terminal_type();
    test_backpressure();
    // Idle phases: none, sender gaps, receiver stalls, both.
    test_random_traffic(105, 0, 0);
    test_random_traffic(105, 77, 0);
    test_random_traffic(105, 0, 77);
    test_random_traffic(105, 25, 25);

    // Drop valid, wait out everything owed, then give stray bytes a chance to show.
    rx.valid <= 1'b0;
    while (owed_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
